// ===== src/pds_pkg.sv =====
`default_nettype none

package pds_pkg;

    localparam int TIME_W = 48;
    localparam int IV_W   = 32;
    localparam int SLOT_W = 4;
    localparam int FUNC_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_REGISTER   = 2'd0,
        FN_UNREGISTER = 2'd1,
        FN_TICK       = 2'd2,
        FN_RECONNECT  = 2'd3
    } func_t;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REVAL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_UPD,
        ST_REVAL,
        ST_SAMPLE
    } state_t;

    // Best-so-far candidate handed from cell to cell during a scan
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] due;
        logic [IV_W-1:0]   iv;
    } cand_t;

endpackage

`default_nettype wire

// ===== src/pds_cell.sv =====
`default_nettype none

module pds_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [IDX_W-1:0]            sel_idx,
    input  wire logic                        reg_en,
    input  wire logic                        unreg_en,
    input  wire logic                        upd_en,
    input  wire logic [pds_pkg::TIME_W-1:0]  wr_due,
    input  wire logic [pds_pkg::IV_W-1:0]    wr_iv,
    input  wire logic                        tok_in,
    input  wire pds_pkg::cand_t              cand_in,
    input  wire logic [IDX_W-1:0]            idx_in,
    output logic                             tok_out,
    output pds_pkg::cand_t                   cand_out,
    output logic [IDX_W-1:0]                 idx_out,
    output logic                             entry_valid
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                       valid_reg;
    logic                       valid_next;
    logic [pds_pkg::TIME_W-1:0] due_reg;
    logic [pds_pkg::TIME_W-1:0] due_next;
    logic [pds_pkg::IV_W-1:0]   iv_reg;
    logic [pds_pkg::IV_W-1:0]   iv_next;
    logic                       tok_reg;
    pds_pkg::cand_t             cand_reg;
    pds_pkg::cand_t             cand_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic                       hit;
    logic                       take;

    assign hit = (sel_idx == MY_IDX);

    // Strict compare: an earlier cell wins ties, giving lowest slot first
    assign take = valid_reg && (!cand_in.valid || (due_reg < cand_in.due));

    always_comb
    begin
        valid_next = valid_reg;
        due_next   = due_reg;
        iv_next    = iv_reg;
        if (hit && reg_en)
        begin
            valid_next = 1'b1;
            due_next   = wr_due;
            iv_next    = wr_iv;
        end
        else if (hit && unreg_en)
        begin
            valid_next = 1'b0;
        end
        else if (hit && upd_en)
        begin
            due_next = wr_due;
        end

        if (take)
        begin
            cand_next.valid = 1'b1;
            cand_next.due   = due_reg;
            cand_next.iv    = iv_reg;
            idx_next        = MY_IDX;
        end
        else
        begin
            cand_next = cand_in;
            idx_next  = idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg  <= due_next;
        iv_reg   <= iv_next;
        cand_reg <= cand_next;
        idx_reg  <= idx_next;
    end

    assign tok_out     = tok_reg;
    assign cand_out    = cand_reg;
    assign idx_out     = idx_reg;
    assign entry_valid = valid_reg;

endmodule

`default_nettype wire

// ===== src/periodic_deadline_scheduler.sv =====
// Register, unregister and reconnect requests, and a tick while disconnected, finish in idle.
// A connected tick scans, passes the calc and update states if the best entry is due, walks
// the slots for revalidates (held while the output stalls), then gives the sample if due.
// The scan length is set by the chain of ENTRIES cells, one cell per cycle.
// Reset clears all entry valid bits, the reconnect flag, the FSM and the output valid flag;
// due times and intervals are left as they are, there is no clearing pass.
`default_nettype none

module periodic_deadline_scheduler #(
    parameter int ENTRIES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [pds_pkg::FUNC_W-1:0]  func,
    input  wire logic [pds_pkg::SLOT_W-1:0]  slot,
    input  wire logic [pds_pkg::IV_W-1:0]    interval_ms,
    input  wire logic [pds_pkg::TIME_W-1:0]  now_ms,
    input  wire logic                        connected,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             kind,
    output logic [pds_pkg::SLOT_W-1:0]       fired_slot,
    output logic                             last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SUM_W = pds_pkg::TIME_W + 1;

    // ------------------------------------------------------------------
    // Cell chain: a candidate plus a token ride from cell 0 to the end,
    // one cell per cycle, each cell swapping in its own entry when earlier.
    // ------------------------------------------------------------------
    logic                 tok_chain  [0:ENTRIES];
    pds_pkg::cand_t       cand_chain [0:ENTRIES];
    logic [IDX_W-1:0]     idx_chain  [0:ENTRIES];
    logic [ENTRIES-1:0]   valid_vec;

    logic                       cell_reg_en;
    logic                       cell_unreg_en;
    logic                       cell_upd_en;
    logic [IDX_W-1:0]           cell_sel;
    logic [pds_pkg::TIME_W-1:0] cell_due;

    pds_pkg::state_t            state_reg;
    pds_pkg::state_t            state_next;

    logic [pds_pkg::TIME_W-1:0] now_reg;
    logic [pds_pkg::TIME_W-1:0] now_next;
    logic                       pend_reg;
    logic                       pend_next;
    logic [ENTRIES-1:0]         rem_reg;
    logic [ENTRIES-1:0]         rem_next;
    logic [IDX_W-1:0]           walk_reg;
    logic [IDX_W-1:0]           walk_next;
    logic                       fire_reg;
    logic                       fire_next;
    logic [pds_pkg::TIME_W-1:0] best_due_reg;
    logic [pds_pkg::TIME_W-1:0] best_due_next;
    logic [pds_pkg::IV_W-1:0]   best_iv_reg;
    logic [pds_pkg::IV_W-1:0]   best_iv_next;
    logic [IDX_W-1:0]           best_idx_reg;
    logic [IDX_W-1:0]           best_idx_next;
    logic [SUM_W-1:0]           sum_due_reg;
    logic [SUM_W-1:0]           sum_due_next;
    logic [SUM_W-1:0]           sum_now_reg;
    logic [SUM_W-1:0]           sum_now_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       kind_reg;
    logic                       kind_next;
    logic [pds_pkg::SLOT_W-1:0] fired_slot_reg;
    logic [pds_pkg::SLOT_W-1:0] fired_slot_next;
    logic                       last_reg;
    logic                       last_next;

    logic                       in_acc;
    logic                       out_free;
    logic                       slot_ok;
    logic                       start_scan;
    logic                       scan_done;
    logic [ENTRIES-1:0]         walk_bit;
    logic [ENTRIES-1:0]         rem_clr;
    logic                       walk_hit;
    logic                       load_reval;
    logic                       load_sample;
    logic [pds_pkg::IV_W-1:0]   step;
    logic [SUM_W-1:0]           new_due_raw;
    logic [pds_pkg::TIME_W-1:0] new_due;

    assign tok_chain[0]  = start_scan;
    assign cand_chain[0] = '0;
    assign idx_chain[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        pds_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .sel_idx     (cell_sel),
            .reg_en      (cell_reg_en),
            .unreg_en    (cell_unreg_en),
            .upd_en      (cell_upd_en),
            .wr_due      (cell_due),
            .wr_iv       (interval_ms),
            .tok_in      (tok_chain[g]),
            .cand_in     (cand_chain[g]),
            .idx_in      (idx_chain[g]),
            .tok_out     (tok_chain[g+1]),
            .cand_out    (cand_chain[g+1]),
            .idx_out     (idx_chain[g+1]),
            .entry_valid (valid_vec[g])
        );
    end

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign slot_ok   = ({{(32 - pds_pkg::SLOT_W){1'b0}}, slot} < 32'(ENTRIES));
    assign scan_done = tok_chain[ENTRIES];

    // Revalidate walk: current slot and what remains after it
    assign walk_bit = ENTRIES'(1) << walk_reg;
    assign rem_clr  = rem_reg & ~walk_bit;
    assign walk_hit = |(rem_reg & walk_bit);

    // Deadline advance: step is max(interval, 1); catch up past now if behind; saturate to the time range
    assign step        = (best_iv_reg == '0) ? pds_pkg::IV_W'(1) : best_iv_reg;
    assign new_due_raw = (sum_due_reg > {1'b0, now_reg}) ? sum_due_reg : sum_now_reg;
    assign new_due     = (new_due_raw > {1'b0, pds_pkg::TIME_MAX}) ?
                         pds_pkg::TIME_MAX : new_due_raw[pds_pkg::TIME_W-1:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                if (in_acc && (pds_pkg::func_t'(func) == pds_pkg::FN_TICK) && connected)
                    state_next = pds_pkg::ST_SCAN;
            end
            pds_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = fire_next ? pds_pkg::ST_CALC : pds_pkg::ST_REVAL;
            end
            pds_pkg::ST_CALC:
            begin
                state_next = pds_pkg::ST_UPD;
            end
            pds_pkg::ST_UPD:
            begin
                state_next = pds_pkg::ST_REVAL;
            end
            pds_pkg::ST_REVAL:
            begin
                if (rem_reg == '0)
                    state_next = fire_reg ? pds_pkg::ST_SAMPLE : pds_pkg::ST_IDLE;
            end
            pds_pkg::ST_SAMPLE:
            begin
                if (out_free)
                    state_next = pds_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pds_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready      = 1'b0;
        start_scan    = 1'b0;
        cell_reg_en   = 1'b0;
        cell_unreg_en = 1'b0;
        cell_upd_en   = 1'b0;
        cell_sel      = IDX_W'(slot);
        cell_due      = now_ms;
        load_reval    = 1'b0;
        load_sample   = 1'b0;
        case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_acc && slot_ok)
                begin
                    cell_reg_en   = (pds_pkg::func_t'(func) == pds_pkg::FN_REGISTER);
                    cell_unreg_en = (pds_pkg::func_t'(func) == pds_pkg::FN_UNREGISTER);
                end
                start_scan = in_acc && (pds_pkg::func_t'(func) == pds_pkg::FN_TICK)
                             && connected;
            end
            pds_pkg::ST_UPD:
            begin
                // write the advanced deadline back into the winning cell
                cell_upd_en = 1'b1;
                cell_sel    = best_idx_reg;
                cell_due    = new_due;
            end
            pds_pkg::ST_REVAL:
            begin
                load_reval = walk_hit && out_free;
            end
            pds_pkg::ST_SAMPLE:
            begin
                load_sample = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        now_next        = now_reg;
        pend_next       = pend_reg;
        rem_next        = rem_reg;
        walk_next       = walk_reg;
        fire_next       = fire_reg;
        best_due_next   = best_due_reg;
        best_iv_next    = best_iv_reg;
        best_idx_next   = best_idx_reg;
        sum_due_next    = sum_due_reg;
        sum_now_next    = sum_now_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        fired_slot_next = fired_slot_reg;
        last_next       = last_reg;

        if (in_acc)
        begin
            if (pds_pkg::func_t'(func) == pds_pkg::FN_RECONNECT)
                pend_next = 1'b1;
            if (start_scan)
            begin
                // snapshot the walk now and drop the reconnect flag
                now_next  = now_ms;
                pend_next = 1'b0;
                rem_next  = pend_reg ? valid_vec : '0;
                walk_next = '0;
            end
        end

        if ((state_reg == pds_pkg::ST_SCAN) && scan_done)
        begin
            fire_next     = cand_chain[ENTRIES].valid && (cand_chain[ENTRIES].due <= now_reg);
            best_due_next = cand_chain[ENTRIES].due;
            best_iv_next  = cand_chain[ENTRIES].iv;
            best_idx_next = idx_chain[ENTRIES];
        end

        if (state_reg == pds_pkg::ST_CALC)
        begin
            sum_due_next = {1'b0, best_due_reg} + SUM_W'(step);
            sum_now_next = {1'b0, now_reg} + SUM_W'(step);
        end

        if ((state_reg == pds_pkg::ST_REVAL) && (rem_reg != '0))
        begin
            // skip empty slots; hold on a valid one while the output stalls
            if (!walk_hit || out_free)
            begin
                walk_next = walk_reg + IDX_W'(1);
                rem_next  = rem_clr;
            end
        end

        if (load_reval)
        begin
            out_valid_next  = 1'b1;
            kind_next       = pds_pkg::KIND_REVAL;
            fired_slot_next = pds_pkg::SLOT_W'(walk_reg);
            last_next       = !fire_reg && (rem_clr == '0);
        end
        else if (load_sample)
        begin
            out_valid_next  = 1'b1;
            kind_next       = pds_pkg::KIND_SAMPLE;
            fired_slot_next = pds_pkg::SLOT_W'(best_idx_reg);
            last_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pds_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            rem_reg       <= '0;
            walk_reg      <= '0;
            fire_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            rem_reg       <= rem_next;
            walk_reg      <= walk_next;
            fire_reg      <= fire_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        best_due_reg   <= best_due_next;
        best_iv_reg    <= best_iv_next;
        best_idx_reg   <= best_idx_next;
        sum_due_reg    <= sum_due_next;
        sum_now_reg    <= sum_now_next;
        kind_reg       <= kind_next;
        fired_slot_reg <= fired_slot_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign fired_slot = fired_slot_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== tb/periodic_deadline_scheduler_tb.sv =====
`default_nettype none

module periodic_deadline_scheduler_tb;

    localparam int ENTRIES       = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 327;
    localparam int LIMIT_TIME    = 8 * 600000;

    // One request as the sender presents it, plus its pacing
    typedef struct {
        pds_pkg::func_t             func;
        logic [pds_pkg::SLOT_W-1:0] slot;
        logic [pds_pkg::IV_W-1:0]   iv;
        logic [pds_pkg::TIME_W-1:0] now;
        logic                       connected;
        int                         gap;
        bit                         drain;
    } sched_req_t;

    // One firing as the block reports it
    typedef struct packed {
        logic                       kind;
        logic [pds_pkg::SLOT_W-1:0] slot;
        logic                       last;
    } firing_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic [pds_pkg::FUNC_W-1:0] func        = '0;
    logic [pds_pkg::SLOT_W-1:0] slot        = '0;
    logic [pds_pkg::IV_W-1:0]   interval_ms = '0;
    logic [pds_pkg::TIME_W-1:0] now_ms      = '0;
    logic                       connected   = 1'b0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic                       kind;
    logic [pds_pkg::SLOT_W-1:0] fired_slot;
    logic                       last;

    periodic_deadline_scheduler #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .slot       (slot),
        .interval_ms(interval_ms),
        .now_ms     (now_ms),
        .connected  (connected),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .fired_slot (fired_slot),
        .last       (last)
    );

    always #4 clk = ~clk;

    // Shadow copy of the schedule table
    logic                       tbl_valid [ENTRIES];
    logic [pds_pkg::TIME_W-1:0] tbl_due   [ENTRIES];
    logic [pds_pkg::IV_W-1:0]   tbl_iv    [ENTRIES];
    logic                       reval_pending;

    sched_req_t request_backlog[$];
    firing_t    expected_firings[$];
    int         error_count   = 0;
    int         results_seen  = 0;
    bit         steady_sender = 1'b0;

    // Apply one accepted request to the shadow table; queue the firings it causes
    task automatic predict_firings(input sched_req_t r);
        int          best;
        int          top;
        bit          fire;
        logic [63:0] step;
        logic [63:0] nxt;
        firing_t     f;
        best = -1;
        top  = -1;
        fire = 1'b0;
        case (r.func)
            pds_pkg::FN_REGISTER:
            begin
                tbl_valid[r.slot] = 1'b1;
                tbl_due[r.slot]   = r.now;
                tbl_iv[r.slot]    = r.iv;
            end
            pds_pkg::FN_UNREGISTER:
            begin
                tbl_valid[r.slot] = 1'b0;
            end
            pds_pkg::FN_RECONNECT:
            begin
                reval_pending = 1'b1;
            end
            pds_pkg::FN_TICK:
            begin
                if (r.connected)
                begin
                    // Earliest due wins, lowest slot on ties
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (tbl_valid[i])
                        begin
                            top = i;
                            if (best < 0 || tbl_due[i] < tbl_due[best])
                                best = i;
                        end
                    end
                    fire = (best >= 0) && (tbl_due[best] <= r.now);
                    if (reval_pending)
                    begin
                        reval_pending = 1'b0;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (tbl_valid[i])
                            begin
                                f.kind = pds_pkg::KIND_REVAL;
                                f.slot = i[pds_pkg::SLOT_W-1:0];
                                f.last = !fire && (i == top);
                                expected_firings.insert(expected_firings.size(), f);
                            end
                        end
                    end
                    if (fire)
                    begin
                        // Advance by max(interval,1); catch up to now if behind; saturate
                        step = (tbl_iv[best] == '0) ? 64'd1 : {32'd0, tbl_iv[best]};
                        nxt  = {16'd0, tbl_due[best]} + step;
                        if (nxt <= {16'd0, r.now})
                            nxt = {16'd0, r.now} + step;
                        if (nxt > {16'd0, pds_pkg::TIME_MAX})
                            nxt = {16'd0, pds_pkg::TIME_MAX};
                        tbl_due[best] = nxt[pds_pkg::TIME_W-1:0];
                        f.kind = pds_pkg::KIND_SAMPLE;
                        f.slot = best[pds_pkg::SLOT_W-1:0];
                        f.last = 1'b1;
                        expected_firings.insert(expected_firings.size(), f);
                    end
                end
            end
        endcase
    endtask

    // Queue one request, drawing its lead-in gap
    task automatic add_req(input pds_pkg::func_t f, input logic [pds_pkg::SLOT_W-1:0] s,
                           input logic [pds_pkg::IV_W-1:0] iv,
                           input logic [pds_pkg::TIME_W-1:0] now, input logic conn,
                           input bit drain);
        sched_req_t r;
        r.func      = f;
        r.slot      = s;
        r.iv        = iv;
        r.now       = now;
        r.connected = conn;
        r.gap       = steady_sender ? 0 : $urandom_range(0, 6);
        r.drain     = drain;
        request_backlog.insert(request_backlog.size(), r);
    endtask

    // Mostly short intervals so entries fire often; some long and fully random ones
    function automatic logic [pds_pkg::IV_W-1:0] pick_interval();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom_range(0, 20);
        else if (sel < 8)
            return $urandom_range(0, 3);
        else if (sel < 9)
            return $urandom_range(100, 5000);
        return $urandom;
    endfunction

    function automatic logic [pds_pkg::TIME_W-1:0] wild_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[pds_pkg::TIME_W-1:0];
    endfunction

    // Driver: present requests from the backlog, hold each until accepted
    sched_req_t inflight;
    int         hold_left;
    bit         armed;
    bit         took;
    bit         launch;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            func        <= pds_pkg::FN_REGISTER;
            slot        <= '0;
            interval_ms <= '0;
            now_ms      <= '0;
            connected   <= 1'b0;
            hold_left    = 0;
            armed        = 1'b0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (took)
                predict_firings(inflight);
            // Only touch the request lines once the current one is gone
            if (!in_valid || took)
            begin
                launch = 1'b0;
                if (request_backlog.size() != 0)
                begin
                    if (!armed)
                    begin
                        hold_left = request_backlog[0].gap +
                                    (request_backlog[0].drain ? SETTLE_CYCLES : 0);
                        armed = 1'b1;
                    end
                    // A draining request counts down only once every firing has arrived
                    if (hold_left == 0)
                        launch = 1'b1;
                    else if (!request_backlog[0].drain || expected_firings.size() == 0)
                        hold_left--;
                end
                if (launch)
                begin
                    inflight     = request_backlog.pop_front();
                    armed        = 1'b0;
                    func        <= inflight.func;
                    slot        <= inflight.slot;
                    interval_ms <= inflight.iv;
                    now_ms      <= inflight.now;
                    connected   <= inflight.connected;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each firing against the oldest expectation, stall at random
    int      stall_left;
    firing_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_firings.size() == 0)
                begin
                    $display("%0t: unexpected firing kind=%0d slot=%0d last=%0d",
                             $time, kind, fired_slot, last);
                    error_count++;
                end
                else
                begin
                    want = expected_firings.pop_front();
                    if (kind !== want.kind)
                    begin
                        $display("%0t: kind mismatch, expected %0d, actual %0d",
                                 $time, want.kind, kind);
                        error_count++;
                    end
                    if (fired_slot !== want.slot)
                    begin
                        $display("%0t: fired_slot mismatch, expected %0d, actual %0d",
                                 $time, want.slot, fired_slot);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %0d, actual %0d",
                                 $time, want.last, last);
                        error_count++;
                    end
                end
                results_seen++;
                // Leave a stretch of results with the receiver always ready
                if (results_seen >= 200 && results_seen < 260)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 6);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int                         n;
        int                         sel;
        int                         waited;
        logic [pds_pkg::TIME_W-1:0] cur_now;
        logic [pds_pkg::TIME_W-1:0] t;
        bit                         drain;

        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_due[i]   = '0;
            tbl_iv[i]    = '0;
        end
        reval_pending = 1'b0;

        // Directed: empty table, zero and all-ones intervals, overwrite, tie on due time,
        // disconnected ticks, repeated reconnect, fall-behind catch-up, saturation at the
        // top of the time range, reconnect with an empty table
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd0,   1'b1, 1'b0);
        add_req(pds_pkg::FN_REGISTER,   4'd0,  32'd0,         48'd100, 1'b1, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd9,  32'd0,         48'd100, 1'b1, 1'b0);
        add_req(pds_pkg::FN_REGISTER,   4'd15, 32'hFFFF_FFFF, 48'd100, 1'b0, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd100, 1'b1, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd100, 1'b1, 1'b0);
        add_req(pds_pkg::FN_REGISTER,   4'd3,  32'd5,         48'd50,  1'b1, 1'b0);
        add_req(pds_pkg::FN_REGISTER,   4'd0,  32'd7,         48'd50,  1'b0, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd50,  1'b1, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd200, 1'b0, 1'b0);
        add_req(pds_pkg::FN_RECONNECT,  4'd0,  32'd0,         48'd200, 1'b1, 1'b0);
        add_req(pds_pkg::FN_RECONNECT,  4'd0,  32'd0,         48'd200, 1'b0, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd200, 1'b0, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd200, 1'b1, 1'b0);
        add_req(pds_pkg::FN_UNREGISTER, 4'd7,  32'd0,         48'd200, 1'b1, 1'b0);
        add_req(pds_pkg::FN_UNREGISTER, 4'd15, 32'd0,         48'd200, 1'b1, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd1000, 1'b1, 1'b0);
        add_req(pds_pkg::FN_UNREGISTER, 4'd0,  32'd0,         48'd1000, 1'b1, 1'b0);
        add_req(pds_pkg::FN_UNREGISTER, 4'd3,  32'd0,         48'd1000, 1'b1, 1'b0);
        add_req(pds_pkg::FN_REGISTER,   4'd5,  32'd1000, pds_pkg::TIME_MAX - 10, 1'b1, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,    pds_pkg::TIME_MAX - 5,  1'b1, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,    pds_pkg::TIME_MAX,      1'b1, 1'b1);
        add_req(pds_pkg::FN_UNREGISTER, 4'd5,  32'd0,    pds_pkg::TIME_MAX,      1'b1, 1'b0);
        add_req(pds_pkg::FN_RECONNECT,  4'd0,  32'd0,         48'd0,   1'b1, 1'b0);
        add_req(pds_pkg::FN_TICK,       4'd0,  32'd0,         48'd0,   1'b1, 1'b0);

        // Fill the whole table, then reconnect and tick for the longest burst
        cur_now = 48'd5000;
        for (int k = 0; k < ENTRIES; k++)
            add_req(pds_pkg::FN_REGISTER, k[pds_pkg::SLOT_W-1:0], pick_interval(),
                    cur_now - $urandom_range(0, 20), 1'($urandom_range(0, 1)), 1'b0);
        add_req(pds_pkg::FN_RECONNECT, pds_pkg::SLOT_W'($urandom_range(0, 15)), $urandom,
                cur_now, 1'($urandom_range(0, 1)), 1'b0);
        add_req(pds_pkg::FN_TICK, pds_pkg::SLOT_W'($urandom_range(0, 15)), $urandom,
                cur_now, 1'b1, 1'b0);

        // Random traffic: mostly advancing ticks over a churning table
        for (n = 1; n <= RANDOM_ITEMS; n++)
        begin
            steady_sender = (n >= 150 && n < 200);
            drain = (n % 80 == 0);
            sel = $urandom_range(0, 99);
            if (sel < 18)
            begin
                t = (sel < 2) ? wild_time() : cur_now;
                add_req(pds_pkg::FN_REGISTER, pds_pkg::SLOT_W'($urandom_range(0, 15)),
                        pick_interval(), t, 1'($urandom_range(0, 1)), drain);
            end
            else if (sel < 26)
            begin
                add_req(pds_pkg::FN_UNREGISTER, pds_pkg::SLOT_W'($urandom_range(0, 15)),
                        $urandom, cur_now, 1'($urandom_range(0, 1)), drain);
            end
            else if (sel < 31)
            begin
                add_req(pds_pkg::FN_RECONNECT, pds_pkg::SLOT_W'($urandom_range(0, 15)),
                        $urandom, cur_now, 1'($urandom_range(0, 1)), drain);
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                add_req(pds_pkg::FN_TICK, pds_pkg::SLOT_W'($urandom_range(0, 15)),
                        $urandom, wild_time(), 1'($urandom_range(0, 1)), drain);
            end
            else
            begin
                cur_now = cur_now + $urandom_range(0, 12);
                add_req(pds_pkg::FN_TICK, pds_pkg::SLOT_W'($urandom_range(0, 15)),
                        $urandom, cur_now, ($urandom_range(0, 9) != 0), drain);
            end
        end
        steady_sender = 1'b0;

        // Single reset at the start; release away from the active edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_backlog.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (expected_firings.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_firings.size() != 0)
        begin
            $display("%0t: %0d expected firings never arrived", $time, expected_firings.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        #(LIMIT_TIME);
        $display("%0t: run timed out", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
